// ===== rtl/core/dsht_pkg.sv =====
`default_nettype none

package dsht_pkg;

   // Counter ceiling shared by the run and window counters
   localparam logic [15:0] CNT_MAX = 16'hFFFF;

   // Register map: index = paddr[3:2]
   localparam int unsigned CSR_ADDR_W = 4;
   localparam logic [1:0] REG_SIGNED_SAMPLES = 2'd0;
   localparam logic [1:0] REG_RCT_CUTOFF     = 2'd1;
   localparam logic [1:0] REG_APT_WINDOW     = 2'd2;
   localparam logic [1:0] REG_APT_CUTOFF     = 2'd3;

   // Reset values of the registers
   localparam logic        RST_SIGNED_SAMPLES = 1'b1;
   localparam logic [15:0] RST_RCT_CUTOFF     = 16'd21;
   localparam logic [15:0] RST_APT_WINDOW     = 16'd1024;
   localparam logic [15:0] RST_APT_CUTOFF     = 16'd589;

   typedef struct packed {
      logic        signed_samples;
      logic [15:0] rct_cutoff;
      logic [15:0] apt_window;
      logic [15:0] apt_cutoff;
   } cfg_type;

   typedef struct packed {
      logic [15:0] sample;
      logic        block_start;
   } req_type;

   typedef struct packed {
      logic bit_valid;
      logic raw_bit;
      logic rct_fail;
      logic apt_fail;
   } rsp_type;

   // Saturating increment of a 16-bit counter
   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      logic [15:0] r;
      if (v == CNT_MAX) begin
         r = CNT_MAX;
      end else begin
         r = v + 16'd1;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dsht_csr.sv =====
`default_nettype none

module dsht_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [dsht_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [31:0]                          csr_pwdata,
   output logic [31:0]                               csr_prdata,
   output logic                                      csr_pready,
   output dsht_pkg::cfg_type                         cfg,
   output logic                                      clear_tests
);

   dsht_pkg::cfg_type cfg_ff;
   dsht_pkg::cfg_type cfg_in;
   logic              wr_en;
   logic [1:0]        reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];

   // Every in-range write also clears the health test state
   assign clear_tests = wr_en;
   assign cfg         = cfg_ff;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            dsht_pkg::REG_SIGNED_SAMPLES: cfg_in.signed_samples = csr_pwdata[0];
            dsht_pkg::REG_RCT_CUTOFF:     cfg_in.rct_cutoff     = csr_pwdata[15:0];
            dsht_pkg::REG_APT_WINDOW:     cfg_in.apt_window     = csr_pwdata[15:0];
            dsht_pkg::REG_APT_CUTOFF:     cfg_in.apt_cutoff     = csr_pwdata[15:0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.signed_samples <= dsht_pkg::RST_SIGNED_SAMPLES;
         cfg_ff.rct_cutoff     <= dsht_pkg::RST_RCT_CUTOFF;
         cfg_ff.apt_window     <= dsht_pkg::RST_APT_WINDOW;
         cfg_ff.apt_cutoff     <= dsht_pkg::RST_APT_CUTOFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      unique case (reg_idx)
         dsht_pkg::REG_SIGNED_SAMPLES: csr_prdata = {31'd0, cfg_ff.signed_samples};
         dsht_pkg::REG_RCT_CUTOFF:     csr_prdata = {16'd0, cfg_ff.rct_cutoff};
         dsht_pkg::REG_APT_WINDOW:     csr_prdata = {16'd0, cfg_ff.apt_window};
         dsht_pkg::REG_APT_CUTOFF:     csr_prdata = {16'd0, cfg_ff.apt_cutoff};
         default:                      csr_prdata = 32'd0;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/dsht_tests.sv =====
`default_nettype none

module dsht_tests (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               clear_tests,
   input  wire logic               advance,
   input  wire dsht_pkg::req_type  item,
   input  wire dsht_pkg::cfg_type  cfg,
   output dsht_pkg::rsp_type       result
);

   logic [15:0] prev_sample_ff, prev_sample_in;
   logic        have_prev_ff, have_prev_in;
   logic        run_valid_ff, run_valid_in;
   logic        run_bit_ff, run_bit_in;
   logic [15:0] run_len_ff, run_len_in;
   logic        win_ref_ff, win_ref_in;
   logic [15:0] win_match_ff, win_match_in;
   logic [15:0] win_pos_ff, win_pos_in;

   logic        make_bit;
   logic [15:0] cmp_a, cmp_b;
   logic        raw_bit;
   logic [15:0] run_len_new;
   logic [15:0] match_new;
   logic [15:0] pos_new;

   // A block start, or no kept sample yet, only primes the comparison
   assign make_bit = ~item.block_start & have_prev_ff;

   // Flip the sign bit so two's complement order becomes unsigned order
   assign cmp_a   = item.sample   ^ {cfg.signed_samples, 15'd0};
   assign cmp_b   = prev_sample_ff ^ {cfg.signed_samples, 15'd0};
   assign raw_bit = cmp_a > cmp_b;

   always_comb begin
      prev_sample_in = prev_sample_ff;
      have_prev_in   = have_prev_ff;
      run_valid_in   = run_valid_ff;
      run_bit_in     = run_bit_ff;
      run_len_in     = run_len_ff;
      win_ref_in     = win_ref_ff;
      win_match_in   = win_match_ff;
      win_pos_in     = win_pos_ff;
      result         = '0;
      run_len_new    = 16'd1;
      match_new      = win_match_ff;
      pos_new        = dsht_pkg::sat_inc(win_pos_ff);

      if (advance) begin
         prev_sample_in = item.sample;
         have_prev_in   = 1'b1;
         if (make_bit) begin
            result.bit_valid = 1'b1;
            result.raw_bit   = raw_bit;

            // Repetition count test
            if (run_valid_ff && (raw_bit == run_bit_ff)) begin
               run_len_new = dsht_pkg::sat_inc(run_len_ff);
            end
            run_valid_in    = 1'b1;
            run_bit_in      = raw_bit;
            run_len_in      = run_len_new;
            result.rct_fail = run_len_new >= cfg.rct_cutoff;

            // Adaptive proportion test
            if (win_pos_ff == 16'd0) begin
               win_ref_in   = raw_bit;
               win_match_in = 16'd1;
               win_pos_in   = 16'd1;
            end else begin
               if (raw_bit == win_ref_ff) begin
                  match_new = dsht_pkg::sat_inc(win_match_ff);
               end
               win_match_in    = match_new;
               result.apt_fail = match_new >= cfg.apt_cutoff;
               win_pos_in      = (pos_new >= cfg.apt_window) ? 16'd0 : pos_new;
            end
         end
      end

      // Register writes restart both tests; the kept sample stays
      if (clear_tests) begin
         run_valid_in = 1'b0;
         run_bit_in   = 1'b0;
         run_len_in   = 16'd0;
         win_ref_in   = 1'b0;
         win_match_in = 16'd0;
         win_pos_in   = 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_sample_ff <= 16'd0;
         have_prev_ff   <= 1'b0;
         run_valid_ff   <= 1'b0;
         run_bit_ff     <= 1'b0;
         run_len_ff     <= 16'd0;
         win_ref_ff     <= 1'b0;
         win_match_ff   <= 16'd0;
         win_pos_ff     <= 16'd0;
      end else begin
         prev_sample_ff <= prev_sample_in;
         have_prev_ff   <= have_prev_in;
         run_valid_ff   <= run_valid_in;
         run_bit_ff     <= run_bit_in;
         run_len_ff     <= run_len_in;
         win_ref_ff     <= win_ref_in;
         win_match_ff   <= win_match_in;
         win_pos_ff     <= win_pos_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/delta_sign_health_tests.sv =====
// Delta-sign raw bit source with repetition count and adaptive proportion tests.
//
// Input channel (req_*): one 16-bit noise sample per item plus block_start.
// An item is taken on a clock edge where req_valid is high and req_stall low.
// Result channel (rsp_*): exactly one result item per input item, in order.
// A block start (or the first sample after reset) returns bit_valid 0.
//
// An accepted item passes the input register, then the result register.
// Throughput: one item per cycle while rsp_stall is low; the compare and
// both counter updates sit between those two registers.
//
// When the receiver holds rsp_stall, the result register keeps its item and
// the input register can still take one more; req_stall rises only once both
// are full. Reset empties the pipeline, restores the register defaults and
// clears all test state. A register write (APB, csr_*) restarts both tests
// and keeps the last sample; write only while the block is idle.
`default_nettype none

module delta_sign_health_tests (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // sample input
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [15:0]                      req_sample,
   input  wire logic                             req_block_start,
   // result output
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_bit_valid,
   output logic                                  rsp_raw_bit,
   output logic                                  rsp_rct_fail,
   output logic                                  rsp_apt_fail,
   // register port
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [dsht_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [31:0]                      csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);

   dsht_pkg::cfg_type cfg;
   logic              clear_tests;

   logic              in_valid_ff, in_valid_in;
   dsht_pkg::req_type in_item_ff, in_item_in;
   logic              out_valid_ff, out_valid_in;
   dsht_pkg::rsp_type out_item_ff, out_item_in;
   dsht_pkg::rsp_type result;

   logic              advance;
   logic              out_free;
   logic              req_take;

   dsht_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .clear_tests (clear_tests)
   );

   dsht_tests u_tests (
      .clock       (clock),
      .reset       (reset),
      .clear_tests (clear_tests),
      .advance     (advance),
      .item        (in_item_ff),
      .cfg         (cfg),
      .result      (result)
   );

   // Pipeline flow control
   assign out_free  = ~out_valid_ff | ~rsp_stall;
   assign advance   = in_valid_ff & out_free;
   assign req_stall = in_valid_ff & ~out_free;
   assign req_take  = req_valid & ~req_stall;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_item_in   = in_item_ff;
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (out_free) begin
         out_valid_in = in_valid_ff;
         out_item_in  = result;
      end
      if (~req_stall) begin
         in_valid_in = req_valid;
         if (req_take) begin
            in_item_in.sample      = req_sample;
            in_item_in.block_start = req_block_start;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_bit_valid = out_item_ff.bit_valid;
   assign rsp_raw_bit   = out_item_ff.raw_bit;
   assign rsp_rct_fail  = out_item_ff.rct_fail;
   assign rsp_apt_fail  = out_item_ff.apt_fail;

   // Checks
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid && !in_valid_ff)
      else $error("pipeline not empty after reset");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("input stalled with room in the pipeline");

   a_no_bit_no_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_bit_valid |-> !rsp_raw_bit && !rsp_rct_fail && !rsp_apt_fail)
      else $error("result flags set without a raw bit");

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !req_stall && !req_valid |=> rsp_valid && !in_valid_ff)
      else $error("input stage item lost");

endmodule

`default_nettype wire
